[src/pchs_pkg.sv]
// pchs_pkg: shared types and constants for the printable character histogram unit
// no dependencies; imported by the parser, the top level and the checker

package pchs_pkg;

    localparam int unsigned HIST_DEPTH = 95;
    localparam int unsigned HIST_AW    = 7;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned REM_W      = 31;

    localparam logic [7:0] CHAR_LOW    = 8'h20;
    localparam logic [7:0] CHAR_HIGH   = 8'h7E;
    localparam logic [7:0] HEADER_TERM = 8'h0A;
    localparam logic [2:0] HDR_LAST    = 3'd4;

    localparam logic KIND_SESSION = 1'b0;
    localparam logic KIND_COUNT   = 1'b1;

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_ABORT = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    // work handed from the parser to the histogram stage
    typedef struct packed {
        logic                 inc;      // bump the counter at addr
        logic                 emit;     // item yields a result
        logic                 query;    // result is a counter read
        logic                 query_ok; // query index in range
        logic                 kind;
        logic [HIST_AW-1:0]   addr;
        logic [CNT_W-1:0]     value;    // session reply value
    } pchs_op_t;

endpackage

[src/pchs_ram.sv]
// pchs_ram: generic single write port, single read port ram with registered read
// no dependencies

module pchs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 95
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/pchs_frame.sv]
// pchs_frame: session framing (header, length, body countdown, session count)
// depends on pchs_pkg; produces one pchs_op_t per accepted item

module pchs_frame (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [1:0]                command,
    input  logic [7:0]                data_byte,
    input  logic [6:0]                char_index,
    output pchs_pkg::pchs_op_t        op
);

    import pchs_pkg::*;

    logic             in_body_reg, in_body_next;
    logic [2:0]       hdr_pos_reg, hdr_pos_next;
    logic [31:0]      len_reg, len_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] sess_cnt_reg, sess_cnt_next;

    logic [REM_W-1:0] rem_dec;
    logic [CNT_W-1:0] cnt_inc;
    logic             printable;
    logic [7:0]       char_off;

    assign rem_dec   = rem_reg - REM_W'(1);
    assign printable = (data_byte >= CHAR_LOW) && (data_byte <= CHAR_HIGH);
    assign char_off  = data_byte - CHAR_LOW;
    assign cnt_inc   = sess_cnt_reg + (printable ? CNT_W'(1) : CNT_W'(0));

    always_comb
    begin
        in_body_next  = in_body_reg;
        hdr_pos_next  = hdr_pos_reg;
        len_next      = len_reg;
        rem_next      = rem_reg;
        sess_cnt_next = sess_cnt_reg;
        op            = '0;

        case (command)
            CMD_QUERY:
            begin
                op.emit     = 1'b1;
                op.query    = 1'b1;
                op.kind     = KIND_COUNT;
                op.query_ok = (char_index < HIST_AW'(HIST_DEPTH));
                op.addr     = op.query_ok ? char_index : '0;
            end
            CMD_ABORT:
            begin
                op.emit      = 1'b1;
                op.kind      = KIND_SESSION;
                op.value     = in_body_reg ? '1 : '0;
                in_body_next = 1'b0;
                hdr_pos_next = '0;
                len_next     = '0;
                rem_next     = '0;
            end
            CMD_BYTE:
            begin
                if (!in_body_reg)
                begin
                    if (hdr_pos_reg != HDR_LAST)
                    begin
                        len_next     = {len_reg[23:0], data_byte};
                        hdr_pos_next = hdr_pos_reg + 3'd1;
                    end
                    else if (data_byte != HEADER_TERM)
                    begin
                        // bad terminator: reply zero
                        op.emit      = 1'b1;
                        op.kind      = KIND_SESSION;
                        hdr_pos_next = '0;
                        len_next     = '0;
                        rem_next     = '0;
                    end
                    else if ((len_reg == '0) || len_reg[31])
                    begin
                        hdr_pos_next = '0;
                        len_next     = '0;
                        rem_next     = '0;
                    end
                    else
                    begin
                        rem_next      = len_reg[REM_W-1:0];
                        sess_cnt_next = '0;
                        hdr_pos_next  = '0;
                        len_next      = '0;
                        in_body_next  = 1'b1;
                    end
                end
                else
                begin
                    op.inc        = printable;
                    op.addr       = char_off[HIST_AW-1:0];
                    sess_cnt_next = cnt_inc;
                    rem_next      = rem_dec;
                    if (rem_dec == '0)
                    begin
                        in_body_next = 1'b0;
                        hdr_pos_next = '0;
                        len_next     = '0;
                        op.emit      = (cnt_inc != '0);
                        op.kind      = KIND_SESSION;
                        op.value     = cnt_inc;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg  <= 1'b0;
            hdr_pos_reg  <= '0;
            len_reg      <= '0;
            rem_reg      <= '0;
            sess_cnt_reg <= '0;
        end
        else if (accept)
        begin
            in_body_reg  <= in_body_next;
            hdr_pos_reg  <= hdr_pos_next;
            len_reg      <= len_next;
            rem_reg      <= rem_next;
            sess_cnt_reg <= sess_cnt_next;
        end
    end

endmodule

[src/printable_char_histogram_session_unit.sv]
// printable_char_histogram_session_unit: top level of the character histogram
// depends on pchs_pkg, pchs_frame and pchs_ram

// The unit takes one item per cycle unless result back-pressure holds it. For
// each accepted item, the first stage runs the session framing and issues
// the histogram read, the second gets the counter from the 95 x 32 ram,
// writes back the incremented count and fills the output register. A run of
// items that hit the same counter keeps the full rate, since the most recent
// write is forwarded past the ram. Back-pressure on the result side stalls
// the pipeline only while the output register is full and not being taken;
// then the item in the second stage waits, whether or not it has a result.
// A new item is taken in the same cycle that a waiting result leaves.
// Counters read as zero after reset through per-entry valid bits, so
// there is no clearing pass and the unit is ready straight out of reset.

module printable_char_histogram_session_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte [7:0], char_index [14:8], zero [15]
    input  logic [1:0]  s_tuser,   // command [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // value [31:0]
    output logic        m_tuser    // result_kind [0]
);

    import pchs_pkg::*;

    logic     s_accept;
    pchs_op_t op0;

    // stage 1: item waiting for its counter read
    pchs_op_t         s1_op_reg;
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_fire;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] out_value_reg;
    logic             out_kind_reg;

    // histogram entries written since reset
    logic [HIST_DEPTH-1:0] hist_vld_reg;

    // last counter write, forwarded past the ram
    logic               fwd_valid_reg;
    logic [HIST_AW-1:0] fwd_addr_reg;
    logic [CNT_W-1:0]   fwd_data_reg;

    logic [CNT_W-1:0] ram_rdata;
    logic [CNT_W-1:0] cur_count;
    logic [CNT_W-1:0] new_count;
    logic             hist_we;
    logic [CNT_W-1:0] result_value;

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_accept = s_tvalid && s_tready;

    pchs_frame u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (s_accept),
        .command    (s_tuser),
        .data_byte  (s_tdata[7:0]),
        .char_index (s_tdata[14:8]),
        .op         (op0)
    );

    pchs_ram #(
        .WIDTH (CNT_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (s1_op_reg.addr),
        .wdata (new_count),
        .re    (s_accept),
        .raddr (op0.addr),
        .rdata (ram_rdata)
    );

    // current counter value: last write wins, unwritten entries read zero
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_op_reg.addr))
        begin
            cur_count = fwd_data_reg;
        end
        else if (hist_vld_reg[s1_op_reg.addr])
        begin
            cur_count = ram_rdata;
        end
        else
        begin
            cur_count = '0;
        end
    end

    assign new_count = cur_count + CNT_W'(1);
    assign hist_we   = s1_fire && s1_op_reg.inc;

    always_comb
    begin
        if (s1_op_reg.query)
        begin
            result_value = s1_op_reg.query_ok ? cur_count : '0;
        end
        else
        begin
            result_value = s1_op_reg.value;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_fire && s1_op_reg.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hist_vld_reg  <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (hist_we)
            begin
                hist_vld_reg[s1_op_reg.addr] <= 1'b1;
                fwd_valid_reg                <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_op_reg <= op0;
        end
        if (s1_fire && s1_op_reg.emit)
        begin
            out_value_reg <= result_value;
            out_kind_reg  <= s1_op_reg.kind;
        end
        if (hist_we)
        begin
            fwd_addr_reg <= s1_op_reg.addr;
            fwd_data_reg <= new_count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_kind_reg;

endmodule

[src/pchs_checker.sv]
// pchs_checker: port-level assertions for the character histogram unit
// depends on printable_char_histogram_session_unit; bound to it below

module pchs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // no result shows once reset has been seen at an edge
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // input is held off only by a full, stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind printable_char_histogram_session_unit pchs_checker u_pchs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/pchs_reply_checker.sv]
// pchs_reply_checker: watches both item channels of the histogram unit, predicts each reply
// and compares it field by field; depends on pchs_pkg only

module pchs_reply_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte [7:0], char_index [14:8], zero [15]
    input  logic [1:0]  s_tuser,   // command [1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // value [31:0]
    input  logic        m_tuser,   // result_kind [0]
    output int          fail_count,
    output int          outstanding,
    output int          results_checked
);

    import pchs_pkg::*;

    typedef struct packed {
        logic             kind;
        logic [CNT_W-1:0] value;
    } reply_t;

    reply_t           replies_due[$];
    logic [CNT_W-1:0] char_totals [HIST_DEPTH];
    logic [CNT_W-1:0] printable_tally;
    logic [REM_W-1:0] body_left;
    logic [31:0]      length_acc;
    logic [2:0]       header_bytes;
    logic             in_body;
    int               mismatches;
    int               compared;

    task automatic drop_session();
        in_body      = 1'b0;
        header_bytes = '0;
        length_acc   = '0;
        body_left    = '0;
    endtask

    task automatic push_reply(input logic kind, input logic [CNT_W-1:0] value);
        reply_t r;
        r.kind  = kind;
        r.value = value;
        replies_due.push_back(r);
    endtask

    // advance the session framing by one accepted item
    task automatic track_item(input logic [1:0] cmd, input logic [7:0] b,
                              input logic [HIST_AW-1:0] ix);
        case (cmd)
            CMD_QUERY:
                push_reply(KIND_COUNT, (ix < HIST_DEPTH) ? char_totals[ix] : '0);
            CMD_ABORT:
            begin
                push_reply(KIND_SESSION, in_body ? '1 : '0);
                drop_session();
            end
            CMD_BYTE:
            begin
                if (!in_body)
                begin
                    if (header_bytes < HDR_LAST)
                    begin
                        length_acc   = {length_acc[23:0], b};
                        header_bytes = header_bytes + 1'b1;
                    end
                    else if (b != HEADER_TERM)
                    begin
                        push_reply(KIND_SESSION, '0);
                        drop_session();
                    end
                    else if (length_acc == '0 || length_acc[31])
                        drop_session();
                    else
                    begin
                        body_left       = length_acc[REM_W-1:0];
                        printable_tally = '0;
                        header_bytes    = '0;
                        length_acc      = '0;
                        in_body         = 1'b1;
                    end
                end
                else
                begin
                    if (b >= CHAR_LOW && b <= CHAR_HIGH)
                    begin
                        char_totals[b - CHAR_LOW] = char_totals[b - CHAR_LOW] + 1'b1;
                        printable_tally           = printable_tally + 1'b1;
                    end
                    body_left = body_left - 1'b1;
                    if (body_left == '0)
                    begin
                        drop_session();
                        if (printable_tally != '0)
                            push_reply(KIND_SESSION, printable_tally);
                    end
                end
            end
            default:
                ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
                char_totals[i] = '0;
            printable_tally = '0;
            drop_session();
            replies_due.delete();
            mismatches      = 0;
            compared        = 0;
            fail_count      <= 0;
            outstanding     <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                compared++;
                if (replies_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result with nothing due: kind %0d value %h",
                                 $realtime, m_tuser, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (want.kind !== m_tuser || want.value !== m_tdata)
                    begin
                        if (mismatches < 10)
                            $display("%0t: mismatch: kind exp %0d got %0d, value exp %h got %h",
                                     $realtime, want.kind, m_tuser, want.value, m_tdata);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                track_item(s_tuser, s_tdata[7:0], s_tdata[14:8]);
            fail_count      <= mismatches;
            outstanding     <= replies_due.size();
            results_checked <= compared;
        end
    end

endmodule

[tb/tb_printable_char_histogram_session_unit.sv]
// tb_printable_char_histogram_session_unit: drives framed byte sessions, aborts and counter
// queries into the histogram unit; depends on pchs_pkg, the unit and pchs_reply_checker

module tb_printable_char_histogram_session_unit;
    import pchs_pkg::*;

    // command code the unit must ignore
    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    // cycles with no handshake on either side before the run is given up
    localparam int         QUIET_LIMIT   = 4000;
    // random items per idling phase, four phases
    localparam int         PHASE_ITEMS   = 490;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // data_byte [7:0], char_index [14:8], zero [15]
    logic [1:0]  s_tuser  = '0;   // command [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // value [31:0]
    logic        m_tuser;         // result_kind [0]

    int fail_count;
    int outstanding;
    int results_checked;

    // idling odds in percent, changed per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int items_sent    = 0;
    int sessions_sent = 0;
    int quiet_cycles  = 0;

    always #5 clk = ~clk;

    printable_char_histogram_session_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    pchs_reply_checker u_reply_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    // result side back-pressure, redrawn every cycle
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // give up when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles, %0d results still due",
                     QUIET_LIMIT, outstanding);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // offer one item and hold it until the unit takes it; valid stays high on return
    // so back-to-back items keep full rate
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] b,
                             input logic [HIST_AW-1:0] ix);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, ix, b};
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    // char_index is a don't-care on stream bytes, so keep it random
    task automatic send_byte(input logic [7:0] b);
        send_item(CMD_BYTE, b, HIST_AW'($urandom));
    endtask

    // big-endian length, then the terminator byte
    task automatic send_header(input logic [31:0] len, input logic [7:0] term);
        send_byte(len[31:24]);
        send_byte(len[23:16]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        send_byte(term);
    endtask

    // mostly printable, with control codes and high bytes mixed in
    function automatic logic [7:0] body_byte();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return 8'($urandom_range(CHAR_LOW, CHAR_HIGH));
        if (pick < 8)
            return 8'($urandom_range(0, 255));
        if (pick == 8)
            return 8'($urandom_range(0, CHAR_LOW - 1));
        return 8'($urandom_range(CHAR_HIGH + 1, 255));
    endfunction

    // counter index, now and then past the end of the histogram
    function automatic logic [HIST_AW-1:0] query_index();
        if ($urandom_range(0, 99) < 85)
            return HIST_AW'($urandom_range(0, HIST_DEPTH - 1));
        return HIST_AW'($urandom_range(HIST_DEPTH, 127));
    endfunction

    initial
    begin
        int roll;
        int body_len;
        int cut;
        int target;
        logic [7:0] term;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling on either side
        send_item(CMD_QUERY, 8'h00, 7'd0);                  // fresh counter reads zero
        send_item(CMD_QUERY, 8'hFF, 7'd127);                // index past the histogram
        send_item(CMD_UNUSED, 8'hFF, 7'd127);               // ignored command
        send_item(CMD_ABORT, 8'h00, 7'd0);                  // abort while awaiting a header
        send_header(32'd3, HEADER_TERM);                    // both printable edges and a high byte
        send_byte(8'h20);
        send_byte(8'h7E);
        send_byte(8'h80);
        send_header(32'd1, 8'h0B);                          // bad terminator
        send_header(32'h8000_0000, HEADER_TERM);            // most negative length
        send_byte(8'h00);                                   // abort part way into a header
        send_byte(8'h00);
        send_item(CMD_ABORT, 8'h00, 7'd0);
        send_header(32'h7FFF_FFFF, HEADER_TERM);            // longest length, cut by an abort
        send_byte(8'h1F);
        send_item(CMD_ABORT, 8'h00, 7'd0);
        send_item(CMD_QUERY, 8'h00, 7'd94);                 // last counter, '~'
        send_item(CMD_QUERY, 8'h00, 7'd0);                  // ' ' after one hit

        // random part in four idling phases
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                begin
                    // well-formed session, sometimes aborted in the body
                    body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 48)
                                                           : $urandom_range(1, 10);
                    cut = ($urandom_range(0, 99) < 8) ? $urandom_range(0, body_len - 1)
                                                      : body_len;
                    send_header(32'(body_len), HEADER_TERM);
                    for (int k = 0; k < cut; k++)
                    begin
                        if ($urandom_range(0, 99) < 6)
                            send_item(CMD_QUERY, 8'($urandom), query_index());
                        if ($urandom_range(0, 99) < 2)
                            send_item(CMD_UNUSED, 8'($urandom), HIST_AW'($urandom));
                        send_byte(body_byte());
                    end
                    if (cut < body_len)
                        send_item(CMD_ABORT, 8'($urandom), HIST_AW'($urandom));
                    sessions_sent++;
                end
                else if (roll < 78)
                begin
                    // any terminator but a newline
                    term = 8'($urandom_range(0, 255));
                    if (term == HEADER_TERM)
                        term = ~term;
                    send_header($urandom, term);
                end
                else if (roll < 86)
                begin
                    // zero or negative length ends quietly
                    send_header(roll[0] ? 32'd0 : {1'b1, 31'($urandom)}, HEADER_TERM);
                end
                else if (roll < 92)
                begin
                    // long session that never completes
                    send_header({1'b0, 31'($urandom)} | 32'h0100_0000, HEADER_TERM);
                    repeat ($urandom_range(0, 6))
                        send_byte(body_byte());
                    send_item(CMD_ABORT, 8'($urandom), HIST_AW'($urandom));
                end
                else
                begin
                    // loose items, then an abort to realign the framing
                    repeat ($urandom_range(1, 6))
                        send_item(2'($urandom_range(0, 3)), 8'($urandom), HIST_AW'($urandom));
                    send_item(CMD_ABORT, 8'($urandom), HIST_AW'($urandom));
                end
                if ($urandom_range(0, 99) < 40)
                    send_item(CMD_QUERY, 8'($urandom), query_index());
            end
        end

        s_tvalid <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (outstanding != 0)
            @(posedge clk);
        // leave room for any stray result from the pipeline
        repeat (8) @(posedge clk);

        $display("sent %0d items (%0d framed sessions) over four idling phases", items_sent,
                 sessions_sent);
        $display("compared %0d results, %0d failures", results_checked, fail_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
